// ===== rtl/cft_pkg.sv =====
package cft_pkg;

  localparam int unsigned FieldNumW = 7;

  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;

  // one queued item: up to two results (a quote, then data, when dbl is set)
  typedef struct packed {
    logic [7:0]           data;
    logic                 dbl;
    logic                 is_content;
    logic                 record_end;
    logic [FieldNumW-1:0] field_number;
    logic                 header_row;
  } cft_entry_t;

endpackage

// ===== rtl/csv_field_tokenizer_unit.sv =====
// A result passes the queue and then the output register before it shows in out_valid_o.
// Throughput: one byte per cycle while the queue is not full; a byte of 0x20 or above after
//   a closing quote, other than quote, backslash, comma or newline, gives two results.
// A 4-entry queue between the classifier and the output register absorbs output stalls.
// Reset (rst_ni low, async): field mode empty, field count zero, header row set,
//   queue and output register empty.
module csv_field_tokenizer_unit #(
  parameter int unsigned MAX_FIELDS  = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_content_o,
  output logic       record_end_o,
  output logic [6:0] field_number_o,
  output logic       header_row_o,
  output logic       last_o
);
  import cft_pkg::*;

  cft_entry_t push_entry, head_entry;
  logic       push, pop, full, empty;

  cft_front #(.MAX_FIELDS(MAX_FIELDS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  cft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_entry)
  );

  cft_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .is_content_o   (is_content_o),
    .record_end_o   (record_end_o),
    .field_number_o (field_number_o),
    .header_row_o   (header_row_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/cft_front.sv =====
module cft_front #(
  parameter int unsigned MAX_FIELDS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output cft_pkg::cft_entry_t entry_o
);
  import cft_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELDS + 1);

  localparam logic [2:0] ModeEmpty    = 3'd0;
  localparam logic [2:0] ModeNormal   = 3'd1;
  localparam logic [2:0] ModeNormEsc  = 3'd2;
  localparam logic [2:0] ModeQuoted   = 3'd3;
  localparam logic [2:0] ModeQuotEsc  = 3'd4;
  localparam logic [2:0] ModeClosed   = 3'd5;

  logic [2:0]        mode_q, mode_d, m;
  logic [CntW-1:0]   count_q, count_d;
  logic              header_q, header_d;
  logic              accept;
  logic              emit, dbl, content, rec, end_f;
  logic [7:0]        data;
  logic [CntW+FieldNumW-1:0] cnt_ext;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign m          = (mode_q > ModeClosed) ? ModeEmpty : mode_q;

  always_comb begin
    emit    = 1'b0;
    dbl     = 1'b0;
    content = 1'b1;
    rec     = 1'b0;
    end_f   = 1'b0;
    data    = in_byte_i;
    mode_d  = m;
    if (in_byte_i == ChComma || in_byte_i == ChNewline) begin
      emit = 1'b1;
      if (m == ModeEmpty || m == ModeNormal || m == ModeClosed) begin
        end_f   = 1'b1;
        content = 1'b0;
        data    = 8'h00;
        rec     = (in_byte_i == ChNewline);
        mode_d  = ModeEmpty;
      end else begin
        mode_d = (m == ModeNormEsc) ? ModeNormal : ModeQuoted;
      end
    end else if (in_byte_i == ChQuote) begin
      unique case (m)
        ModeEmpty:  mode_d = ModeQuoted;
        ModeQuoted: mode_d = ModeClosed;
        ModeNormal, ModeNormEsc: begin
          emit   = 1'b1;
          mode_d = ModeNormal;
        end
        default: begin
          emit   = 1'b1;
          mode_d = ModeQuoted;
        end
      endcase
    end else if (in_byte_i == ChBslash) begin
      unique case (m)
        ModeEmpty, ModeNormal: mode_d = ModeNormEsc;
        ModeQuoted:            mode_d = ModeQuotEsc;
        ModeNormEsc: begin
          emit   = 1'b1;
          mode_d = ModeNormal;
        end
        ModeQuotEsc: begin
          emit   = 1'b1;
          mode_d = ModeQuoted;
        end
        default: begin
          emit   = 1'b1;
          data   = ChQuote;
          mode_d = ModeNormEsc;
        end
      endcase
    end else if (in_byte_i >= ChSpace) begin
      emit   = 1'b1;
      dbl    = (m == ModeClosed);
      mode_d = (m == ModeQuoted || m == ModeQuotEsc) ? ModeQuoted : ModeNormal;
    end
  end

  always_comb begin
    count_d  = count_q;
    header_d = header_q;
    if (end_f) begin
      if (rec) begin
        count_d  = '0;
        header_d = 1'b0;
      end else if (count_q < CntW'(MAX_FIELDS)) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeEmpty;
      count_q  <= '0;
      header_q <= 1'b1;
    end else if (accept) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      header_q <= header_d;
    end
  end

  assign cnt_ext = {{FieldNumW{1'b0}}, count_q};

  assign push_o                = accept && emit;
  assign entry_o.data          = data;
  assign entry_o.dbl           = dbl;
  assign entry_o.is_content    = content;
  assign entry_o.record_end    = rec;
  assign entry_o.field_number  = cnt_ext[FieldNumW-1:0];
  assign entry_o.header_row    = header_q;

endmodule

// ===== rtl/cft_queue.sv =====
module cft_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cft_pkg::cft_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output cft_pkg::cft_entry_t head_o
);
  import cft_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cft_entry_t      store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;

  assign full_o  = (fill_q == CntW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/cft_back.sv =====
module cft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  cft_pkg::cft_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                is_content_o,
  output logic                record_end_o,
  output logic [6:0]          field_number_o,
  output logic                header_row_o,
  output logic                last_o
);
  import cft_pkg::*;

  logic       valid_q;
  logic       second_q;
  logic       load;
  logic       first_half;
  logic [7:0] byte_q;
  logic       content_q, rec_q, header_q, last_q;
  logic [FieldNumW-1:0] num_q;

  assign load       = (!valid_q || out_ready_i) && !empty_i;
  assign first_half = head_i.dbl && !second_q;
  assign pop_o      = load && !first_half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q  <= 1'b1;
        second_q <= first_half;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= first_half ? ChQuote : head_i.data;
      content_q <= head_i.is_content;
      rec_q     <= head_i.record_end;
      num_q     <= head_i.field_number;
      header_q  <= head_i.header_row;
      last_q    <= !first_half;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign is_content_o   = content_q;
  assign record_end_o   = rec_q;
  assign field_number_o = num_q;
  assign header_row_o   = header_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/cft_checker.sv =====
module cft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_content_o,
  input logic       record_end_o,
  input logic       last_o
);
  import cft_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("result changed while stalled");

  // first of a pair is always the held-back quote
  a_pair_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> is_content_o && out_byte_o == ChQuote && !record_end_o)
    else $error("non-last result is not a quote");

  // second of a pair follows right away
  a_pair_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && last_o && is_content_o)
    else $error("pair not completed next cycle");

  // field end marker is a lone, zero-byte result
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_content_o |-> last_o && out_byte_o == 8'h00)
    else $error("bad field end marker");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .is_content_o (is_content_o),
  .record_end_o (record_end_o),
  .last_o       (last_o)
);
